[rtl/etd_pkg.sv]
// Package for the envelope trigger detector: register indexes, port widths,
// reset values of the configuration registers. No dependencies.
package etd_pkg;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MAIN_ENABLE      = 3'd0,
        REG_SIDECHAIN_ENABLE = 3'd1,
        REG_LEVEL_THRESHOLD  = 3'd2,
        REG_ATTACK_COEFF     = 3'd3,
        REG_RELEASE_COEFF    = 3'd4,
        REG_COOLDOWN_LENGTH  = 3'd5
    } cfg_index_t;

    // Register widths as the register map gives them.
    localparam int THRESH_REG_BITS   = 24;
    localparam int COEFF_REG_BITS    = 16;
    localparam int COOLDOWN_BITS     = 16;

    // Reset values.
    localparam logic [THRESH_REG_BITS-1:0] THRESH_RESET   = 24'd838861;
    localparam logic [COEFF_REG_BITS-1:0]  ATTACK_RESET   = 16'd64185;
    localparam logic [COEFF_REG_BITS-1:0]  RELEASE_RESET  = 16'd65522;
    localparam logic [COOLDOWN_BITS-1:0]   COOLDOWN_RESET = 16'd2400;

    // Stream payload layout.
    localparam int IN_USER_BITS  = 3;   // main_mono, side_mono, side_present
    localparam int LEVEL_BITS    = 24;
    localparam int OUT_RAW_BITS  = 3 + 2 * LEVEL_BITS;
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

endpackage

[rtl/etd_follow.sv]
// One channel of the peak envelope follower: magnitude of a signed sample and
// one rounded one-pole step toward it. Purely combinational; no dependencies.
module etd_follow #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEFF_BITS  = 16
) (
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [SAMPLE_BITS-1:0] env,
    input  logic [COEFF_BITS-1:0]  attack_coeff,
    input  logic [COEFF_BITS-1:0]  release_coeff,
    output logic [SAMPLE_BITS-1:0] env_next
);

    localparam int PROD_BITS = SAMPLE_BITS + COEFF_BITS + 1;

    logic [SAMPLE_BITS-1:0] mag;
    logic                   rising;
    logic [SAMPLE_BITS-1:0] diff;
    logic [COEFF_BITS:0]    gain;
    logic [PROD_BITS-1:0]   prod;
    logic [PROD_BITS-1:0]   rounded;
    logic [SAMPLE_BITS-1:0] step;

    // Two's complement negate; the most negative code maps onto its own
    // magnitude, which still fits unsigned in SAMPLE_BITS.
    assign mag    = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
    assign rising = mag > env;
    assign diff   = rising ? (mag - env) : (env - mag);

    always_comb
    begin
        gain = {1'b1, {COEFF_BITS{1'b0}}}
             - {1'b0, (rising ? attack_coeff : release_coeff)};
    end

    // Round the step up so the envelope always moves by at least one toward a differing magnitude.
    assign prod    = PROD_BITS'(diff) * PROD_BITS'(gain);
    assign rounded = prod + PROD_BITS'({COEFF_BITS{1'b1}});
    assign step    = SAMPLE_BITS'(rounded >> COEFF_BITS);

    assign env_next = rising ? (env + step) : (env - step);

endmodule

[rtl/envelope_trigger_detector_top.sv]
// Top level of the envelope trigger detector: input register, four envelope
// channels, trigger logic and result register. Uses etd_pkg and etd_follow.
//
//  Channel   Direction  Payload
//  --------  ---------  ------------------------------------------------------
//  s_*       in         tdata: main_left, main_right, side_left, side_right
//                       tuser: main_mono, side_mono, side_present; tlast: block_end
//  m_*       out        tdata: main_trigger, side_trigger, block_trigger,
//                       main_level, side_level; tlast: last_of_block
//  cfg_*     in         write enable, register index, write data
//
// Every word is captured in the input register, passes the envelope, threshold
// and cooldown logic combinationally, and lands in the result register, so a
// new word is accepted every cycle while the result side does not stall. The
// four channel multipliers work in parallel, and the envelope state loop runs
// from the envelope registers through combinational logic only. A stalled
// result holds the result register and, behind it, the input register; an
// input word is still taken while the result waits if the input register is
// empty. Reset (rst_n low, asynchronous) empties both registers, zeroes the
// envelopes, edge flags, cooldown and block accumulator, and loads the
// configuration defaults.
module envelope_trigger_detector_top #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEFF_BITS  = 16,
    // Input tdata is the four samples packed, padded up to whole bytes.
    parameter int IN_DATA_BITS = ((4 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic clk,
    input  logic rst_n,

    // Input words.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // From bit 0: main_left, main_right, side_left, side_right (SAMPLE_BITS each).
    input  logic [IN_DATA_BITS-1:0]            s_tdata,
    // From bit 0: main_mono, side_mono, side_present.
    input  logic [etd_pkg::IN_USER_BITS-1:0]   s_tuser,
    input  logic                               s_tlast,

    // Result words.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // From bit 0: main_trigger, side_trigger, block_trigger, main_level (24),
    // side_level (24), zero padding.
    output logic [etd_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    output logic                               m_tlast,

    // Configuration writes.
    input  logic                               cfg_we,
    input  logic [etd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [etd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

    import etd_pkg::*;

    // The threshold keeps at most SAMPLE_BITS bits and each pole at most
    // COEFF_BITS bits of what the register map allows.
    localparam int TH_BITS = (SAMPLE_BITS < THRESH_REG_BITS) ? SAMPLE_BITS : THRESH_REG_BITS;
    localparam int CF_BITS = (COEFF_BITS < COEFF_REG_BITS) ? COEFF_BITS : COEFF_REG_BITS;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic                     main_enable_reg;
    logic                     side_enable_reg;
    logic [TH_BITS-1:0]       threshold_reg;
    logic [CF_BITS-1:0]       attack_reg;
    logic [CF_BITS-1:0]       release_reg;
    logic [COOLDOWN_BITS-1:0] cooldown_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_enable_reg     <= 1'b1;
            side_enable_reg     <= 1'b0;
            threshold_reg       <= THRESH_RESET[TH_BITS-1:0];
            attack_reg          <= ATTACK_RESET[CF_BITS-1:0];
            release_reg         <= RELEASE_RESET[CF_BITS-1:0];
            cooldown_length_reg <= COOLDOWN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_MAIN_ENABLE:      main_enable_reg     <= cfg_wdata[0];
                REG_SIDECHAIN_ENABLE: side_enable_reg     <= cfg_wdata[0];
                REG_LEVEL_THRESHOLD:  threshold_reg       <= cfg_wdata[TH_BITS-1:0];
                REG_ATTACK_COEFF:     attack_reg          <= cfg_wdata[CF_BITS-1:0];
                REG_RELEASE_COEFF:    release_reg         <= cfg_wdata[CF_BITS-1:0];
                REG_COOLDOWN_LENGTH:  cooldown_length_reg <= cfg_wdata[COOLDOWN_BITS-1:0];
                default:              ;   // indexes past the map are ignored
            endcase
        end
    end

    logic [COEFF_BITS-1:0]  attack_coeff;
    logic [COEFF_BITS-1:0]  release_coeff;
    logic [SAMPLE_BITS-1:0] threshold;

    assign attack_coeff  = COEFF_BITS'(attack_reg);
    assign release_coeff = COEFF_BITS'(release_reg);
    assign threshold     = SAMPLE_BITS'(threshold_reg);

    // ------------------------------------------------------------------
    // Handshake. The input register advances whenever the result register
    // is empty or being drained this cycle.
    // ------------------------------------------------------------------
    logic                    in_valid_reg;
    logic [4*SAMPLE_BITS-1:0] in_data_reg;
    logic [IN_USER_BITS-1:0] in_user_reg;
    logic                    in_last_reg;
    logic                    out_valid_reg;
    logic [OUT_DATA_BITS-1:0] out_data_reg;
    logic                    out_last_reg;
    logic                    advance;
    logic                    proc_en;

    assign advance  = !out_valid_reg || m_tready;
    assign proc_en  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata[4*SAMPLE_BITS-1:0];
            in_user_reg <= s_tuser;
            in_last_reg <= s_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Envelope channels: main left, main right, side left, side right.
    // A mono path feeds its left sample to both channels.
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] env_reg  [4];
    logic [SAMPLE_BITS-1:0] env_calc [4];
    logic [SAMPLE_BITS-1:0] chan_sample [4];
    logic                   main_mono;
    logic                   side_mono;
    logic                   side_present;

    assign main_mono    = in_user_reg[0];
    assign side_mono    = in_user_reg[1];
    assign side_present = in_user_reg[2];

    assign chan_sample[0] = in_data_reg[0*SAMPLE_BITS +: SAMPLE_BITS];
    assign chan_sample[1] = main_mono ? in_data_reg[0*SAMPLE_BITS +: SAMPLE_BITS]
                                      : in_data_reg[1*SAMPLE_BITS +: SAMPLE_BITS];
    assign chan_sample[2] = in_data_reg[2*SAMPLE_BITS +: SAMPLE_BITS];
    assign chan_sample[3] = side_mono ? in_data_reg[2*SAMPLE_BITS +: SAMPLE_BITS]
                                      : in_data_reg[3*SAMPLE_BITS +: SAMPLE_BITS];

    for (genvar ch = 0; ch < 4; ch++)
    begin : g_chan
        etd_follow #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .COEFF_BITS  (COEFF_BITS)
        ) u_follow (
            .sample        (chan_sample[ch]),
            .env           (env_reg[ch]),
            .attack_coeff  (attack_coeff),
            .release_coeff (release_coeff),
            .env_next      (env_calc[ch])
        );
    end

    // ------------------------------------------------------------------
    // Trigger logic. A path that does not run holds its envelopes and edge
    // flag, gives no trigger and reports the held level.
    // ------------------------------------------------------------------
    logic                     main_run;
    logic                     side_run;
    logic [SAMPLE_BITS-1:0]   env_next [4];
    logic [SAMPLE_BITS-1:0]   main_level;
    logic [SAMPLE_BITS-1:0]   side_level;
    logic                     main_above_reg;
    logic                     main_above_next;
    logic                     side_above_reg;
    logic                     side_above_next;
    logic [COOLDOWN_BITS-1:0] cooldown_reg;
    logic [COOLDOWN_BITS-1:0] cooldown_next;
    logic [COOLDOWN_BITS-1:0] cooldown_dec;
    logic                     block_accum_reg;
    logic                     block_accum_next;
    logic                     main_trigger;
    logic                     side_trigger;
    logic                     block_trigger;
    logic                     main_hit;
    logic                     side_hit;

    assign main_run = main_enable_reg;
    assign side_run = side_enable_reg && side_present;

    assign env_next[0] = main_run ? env_calc[0] : env_reg[0];
    assign env_next[1] = main_run ? env_calc[1] : env_reg[1];
    assign env_next[2] = side_run ? env_calc[2] : env_reg[2];
    assign env_next[3] = side_run ? env_calc[3] : env_reg[3];

    assign main_level = (env_next[0] > env_next[1]) ? env_next[0] : env_next[1];
    assign side_level = (env_next[2] > env_next[3]) ? env_next[2] : env_next[3];

    assign main_hit = main_level > threshold;
    assign side_hit = side_level > threshold;

    always_comb
    begin
        // The cooldown ticks before the edge test, so a trigger can fire on
        // the frame where the count reaches zero.
        cooldown_dec    = (cooldown_reg != '0) ? (cooldown_reg - 1'b1) : cooldown_reg;
        main_trigger    = 1'b0;
        main_above_next = main_above_reg;
        cooldown_next   = cooldown_reg;
        if (main_run)
        begin
            main_trigger    = main_hit && !main_above_reg && (cooldown_dec == '0);
            main_above_next = main_hit;
            cooldown_next   = main_trigger ? cooldown_length_reg : cooldown_dec;
        end

        side_trigger    = side_run && side_hit && !side_above_reg;
        side_above_next = side_run ? side_hit : side_above_reg;

        block_trigger    = block_accum_reg || main_trigger || side_trigger;
        block_accum_next = in_last_reg ? 1'b0 : block_trigger;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                env_reg[i] <= '0;
            end
            main_above_reg  <= 1'b0;
            side_above_reg  <= 1'b0;
            cooldown_reg    <= '0;
            block_accum_reg <= 1'b0;
        end
        else if (proc_en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                env_reg[i] <= env_next[i];
            end
            main_above_reg  <= main_above_next;
            side_above_reg  <= side_above_next;
            cooldown_reg    <= cooldown_next;
            block_accum_reg <= block_accum_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_en)
        begin
            out_data_reg <= OUT_DATA_BITS'({LEVEL_BITS'(side_level),
                                            LEVEL_BITS'(main_level),
                                            block_trigger,
                                            side_trigger,
                                            main_trigger});
            out_last_reg <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // A word in the input register is never dropped while the result side stalls.
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input word lost during stall");

    // A main trigger reloads the cooldown from its register.
    a_cooldown_load: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_en && main_trigger) |=> (cooldown_reg == $past(cooldown_length_reg)))
        else $error("cooldown not reloaded after main trigger");

    // The block flag of a result covers both path triggers of that result.
    a_block_covers: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg[0] || out_data_reg[1])) |-> out_data_reg[2])
        else $error("block trigger misses a path trigger");

    // A frozen main path keeps its envelopes.
    a_main_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_en && !main_enable_reg) |=>
            (env_reg[0] == $past(env_reg[0]) && env_reg[1] == $past(env_reg[1])))
        else $error("main envelope moved while disabled");

    // The accumulator is clear after the last frame of a block.
    a_block_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_en && in_last_reg) |=> !block_accum_reg)
        else $error("block accumulator not cleared at block end");
`endif

endmodule

[test/tb_envelope_trigger_detector_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for envelope_trigger_detector_top: streams stereo frame words,
// predicts the trigger flags and envelope levels of each one and checks every result word.
// Depends on etd_pkg and the detector RTL; needs no files or arguments.

module tb_envelope_trigger_detector_top;

    import etd_pkg::*;

    // Block geometry; these match the defaults of the top level.
    localparam int SAMPLE_BITS  = 24;
    localparam int COEFF_BITS   = 16;
    localparam int IN_DATA_BITS = ((4 * SAMPLE_BITS + 7) / 8) * 8;

    // Run control.
    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 12;
    localparam int SETTLE_CYCLES    = 4;     // margin for the input and result registers to drain
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int MAX_REPORTS      = 10;
    localparam int RANDOM_PHASES    = 7;
    localparam int FRAMES_PER_PHASE = 250;

    // Sample values and levels at the ends of the range.
    localparam logic [SAMPLE_BITS-1:0] NEG_FULL_SCALE   = 24'h800000;
    localparam logic [SAMPLE_BITS-1:0] POS_FULL_SCALE   = 24'h7FFFFF;
    localparam logic [SAMPLE_BITS-1:0] MINUS_ONE        = 24'hFFFFFF;
    localparam logic [SAMPLE_BITS-1:0] LEVEL_FULL_SCALE = 24'd8388608;
    localparam logic [COEFF_BITS-1:0]  COEFF_MAX        = '1;
    localparam logic [COOLDOWN_BITS-1:0] COOLDOWN_MAX   = '1;

    // Register indexes past the end of the map; writes there must change nothing.
    localparam logic [CFG_INDEX_BITS-1:0] SPARE_INDEX_FIRST =
        CFG_INDEX_BITS'(REG_COOLDOWN_LENGTH + 1);
    localparam logic [CFG_INDEX_BITS-1:0] SPARE_INDEX_LAST  = '1;

    // One input word, unpacked into its fields.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] main_left;
        logic [SAMPLE_BITS-1:0] main_right;
        logic [SAMPLE_BITS-1:0] side_left;
        logic [SAMPLE_BITS-1:0] side_right;
        logic                   main_mono;
        logic                   side_mono;
        logic                   side_present;
        logic                   block_end;
    } frame_t;

    // One result word, unpacked into its fields.
    typedef struct packed {
        logic                  main_trigger;
        logic                  side_trigger;
        logic                  block_trigger;
        logic [LEVEL_BITS-1:0] main_level;
        logic [LEVEL_BITS-1:0] side_level;
        logic                  last_of_block;
    } report_t;

    // Raw write data for each register, upper bits included.
    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] main_enable;
        logic [CFG_DATA_BITS-1:0] sidechain_enable;
        logic [CFG_DATA_BITS-1:0] level_threshold;
        logic [CFG_DATA_BITS-1:0] attack_coeff;
        logic [CFG_DATA_BITS-1:0] release_coeff;
        logic [CFG_DATA_BITS-1:0] cooldown_length;
    } settings_t;

    // Loudness classes for the random sample segments.
    typedef enum int {
        LVL_SILENT,
        LVL_QUIET,
        LVL_MID,
        LVL_LOUD,
        LVL_EXTREME,
        LVL_NOISE
    } level_kind_t;

    // Every input starts at a known value.
    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [IN_DATA_BITS-1:0]   s_tdata   = '0;
    logic [IN_USER_BITS-1:0]   s_tuser   = '0;
    logic                      s_tlast   = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [OUT_DATA_BITS-1:0]  m_tdata;
    logic                      m_tlast;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

    envelope_trigger_detector_top #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COEFF_BITS (COEFF_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Our own copy of the register file, as the block should hold it.
    logic                     run_main;
    logic                     run_side;
    logic [SAMPLE_BITS-1:0]   trip_level;
    logic [COEFF_BITS-1:0]    attack_pole;
    logic [COEFF_BITS-1:0]    release_pole;
    logic [COOLDOWN_BITS-1:0] holdoff_length;

    // Our own copy of the detector state: envelopes are main L, main R, side L, side R.
    logic [SAMPLE_BITS-1:0]   env_model [4];
    logic                     main_was_above;
    logic                     side_was_above;
    logic [COOLDOWN_BITS-1:0] holdoff_left;
    logic                     block_flag;

    // Result words predicted for accepted frames and not yet seen on the output.
    report_t reports_due [$];

    // Idling controls: a zero turns that side's idling off.
    int unsigned gap_max      = 0;
    int unsigned rx_stall_max = 0;
    int unsigned burst_left   = 0;
    int unsigned ready_hold   = 0;
    logic        ready_phase  = 1'b0;

    // Random segment state for the main and sidechain signals.
    level_kind_t main_kind;
    level_kind_t side_kind;
    int unsigned main_seg_left = 0;
    int unsigned side_seg_left = 0;

    // Bookkeeping for the summary and the verdict.
    int unsigned frames_sent    = 0;
    int unsigned words_checked  = 0;
    int unsigned main_trig_seen = 0;
    int unsigned side_trig_seen = 0;
    int unsigned blocks_closed  = 0;
    int unsigned settings_used  = 0;
    int unsigned mismatches     = 0;
    int unsigned idle_cycles    = 0;

    // ------------------------------------------------------------------
    // Envelope and trigger prediction
    // ------------------------------------------------------------------

    // Magnitude of a two's complement sample; the full-scale negative value keeps
    // its magnitude exactly, which needs the whole width as an unsigned number.
    function automatic logic [SAMPLE_BITS-1:0] sample_magnitude(logic [SAMPLE_BITS-1:0] raw);
        if (raw[SAMPLE_BITS-1])
            return -raw;
        return raw;
    endfunction

    // One-pole peak follower. The step is rounded up, so the envelope always moves
    // toward a differing magnitude by at least one and never overshoots it.
    function automatic logic [SAMPLE_BITS-1:0] env_follow(logic [SAMPLE_BITS-1:0] env,
                                                          logic [SAMPLE_BITS-1:0] mag);
        logic [63:0] gain;
        logic [63:0] span;
        logic [63:0] move;
        if (mag > env) begin
            gain = (64'd1 << COEFF_BITS) - 64'(attack_pole);
            span = 64'(mag - env);
        end else begin
            gain = (64'd1 << COEFF_BITS) - 64'(release_pole);
            span = 64'(env - mag);
        end
        move = (span * gain + (64'd1 << COEFF_BITS) - 64'd1) >> COEFF_BITS;
        if (mag > env)
            return env + move[SAMPLE_BITS-1:0];
        return env - move[SAMPLE_BITS-1:0];
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] louder(logic [SAMPLE_BITS-1:0] a,
                                                      logic [SAMPLE_BITS-1:0] b);
        return (a > b) ? a : b;
    endfunction

    task automatic reset_tracker();
        run_main       = 1'b1;
        run_side       = 1'b0;
        trip_level     = THRESH_RESET;
        attack_pole    = ATTACK_RESET;
        release_pole   = RELEASE_RESET;
        holdoff_length = COOLDOWN_RESET;
        for (int i = 0; i < 4; i++)
            env_model[i] = '0;
        main_was_above = 1'b0;
        side_was_above = 1'b0;
        holdoff_left   = '0;
        block_flag     = 1'b0;
    endtask

    // Advances the state by one accepted frame and returns the word it must produce.
    task automatic track_frame(input frame_t f, output report_t r);
        logic [SAMPLE_BITS-1:0] mag_l;
        logic [SAMPLE_BITS-1:0] mag_r;
        logic                   above;
        r = '0;
        // A frozen path keeps its envelopes, its edge flag and the cooldown count.
        if (run_main) begin
            mag_l = sample_magnitude(f.main_left);
            mag_r = f.main_mono ? mag_l : sample_magnitude(f.main_right);
            env_model[0] = env_follow(env_model[0], mag_l);
            env_model[1] = env_follow(env_model[1], mag_r);
            if (holdoff_left != 0)
                holdoff_left--;
            above = louder(env_model[0], env_model[1]) > trip_level;
            if (above && !main_was_above && holdoff_left == 0) begin
                r.main_trigger = 1'b1;
                holdoff_left   = holdoff_length;
            end
            main_was_above = above;
        end
        // The sidechain also stands still on frames where it is not connected.
        if (run_side && f.side_present) begin
            mag_l = sample_magnitude(f.side_left);
            mag_r = f.side_mono ? mag_l : sample_magnitude(f.side_right);
            env_model[2] = env_follow(env_model[2], mag_l);
            env_model[3] = env_follow(env_model[3], mag_r);
            above = louder(env_model[2], env_model[3]) > trip_level;
            r.side_trigger = above && !side_was_above;
            side_was_above = above;
        end
        r.main_level    = louder(env_model[0], env_model[1]);
        r.side_level    = louder(env_model[2], env_model[3]);
        // The block flag reports this frame too, then clears at the end of a block.
        r.block_trigger = block_flag | r.main_trigger | r.side_trigger;
        block_flag      = f.block_end ? 1'b0 : r.block_trigger;
        r.last_of_block = f.block_end;
    endtask

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------

    // Leaves cfg_we high; the caller lowers it after its last write.
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0]  value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        case (idx)
            REG_MAIN_ENABLE:      run_main       = value[0];
            REG_SIDECHAIN_ENABLE: run_side       = value[0];
            REG_LEVEL_THRESHOLD:  trip_level     = value[SAMPLE_BITS-1:0];
            REG_ATTACK_COEFF:     attack_pole    = value[COEFF_BITS-1:0];
            REG_RELEASE_COEFF:    release_pole   = value[COEFF_BITS-1:0];
            REG_COOLDOWN_LENGTH:  holdoff_length = value[COOLDOWN_BITS-1:0];
            default: ;
        endcase
    endtask

    // Writes the whole register map; only called while the block is idle.
    task automatic apply_settings(input settings_t s, input bit with_spare);
        write_register(REG_MAIN_ENABLE,      s.main_enable);
        write_register(REG_SIDECHAIN_ENABLE, s.sidechain_enable);
        write_register(REG_LEVEL_THRESHOLD,  s.level_threshold);
        write_register(REG_ATTACK_COEFF,     s.attack_coeff);
        write_register(REG_RELEASE_COEFF,    s.release_coeff);
        write_register(REG_COOLDOWN_LENGTH,  s.cooldown_length);
        if (with_spare)
            write_register(CFG_INDEX_BITS'($urandom_range(SPARE_INDEX_FIRST, SPARE_INDEX_LAST)),
                           CFG_DATA_BITS'($urandom));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic settings_t plain_settings(logic main_on, logic side_on,
                                                 logic [SAMPLE_BITS-1:0] threshold,
                                                 logic [COEFF_BITS-1:0] attack,
                                                 logic [COEFF_BITS-1:0] release_pole_val,
                                                 logic [COOLDOWN_BITS-1:0] cooldown);
        settings_t s;
        s.main_enable      = CFG_DATA_BITS'(main_on);
        s.sidechain_enable = CFG_DATA_BITS'(side_on);
        s.level_threshold  = CFG_DATA_BITS'(threshold);
        s.attack_coeff     = CFG_DATA_BITS'(attack);
        s.release_coeff    = CFG_DATA_BITS'(release_pole_val);
        s.cooldown_length  = CFG_DATA_BITS'(cooldown);
        return s;
    endfunction

    // Random register values; the unused upper bits of the narrow registers carry
    // noise so that the block has to ignore them. With corners set, every register
    // sits at one end of its range.
    function automatic settings_t random_settings(bit corners);
        settings_t s;
        logic [COEFF_BITS-1:0]    attack;
        logic [COEFF_BITS-1:0]    release_pole_val;
        logic [COOLDOWN_BITS-1:0] cooldown;
        s.main_enable         = CFG_DATA_BITS'($urandom);
        s.main_enable[0]      = ($urandom_range(0, 5) != 0);
        s.sidechain_enable    = CFG_DATA_BITS'($urandom);
        s.sidechain_enable[0] = ($urandom_range(0, 3) != 0);
        if (corners) begin
            s.level_threshold = $urandom_range(0, 1) ? '0 : CFG_DATA_BITS'(LEVEL_FULL_SCALE);
            attack            = $urandom_range(0, 1) ? '0 : COEFF_MAX;
            release_pole_val  = $urandom_range(0, 1) ? '0 : COEFF_MAX;
            cooldown          = $urandom_range(0, 1) ? '0 : COOLDOWN_MAX;
        end else begin
            if ($urandom_range(0, 3) == 0)
                s.level_threshold = CFG_DATA_BITS'($urandom_range(0, LEVEL_FULL_SCALE));
            else
                s.level_threshold = CFG_DATA_BITS'($urandom_range(1 << 14, 1 << 22));
            case ($urandom_range(0, 2))
                0:       attack = COEFF_BITS'($urandom);
                1:       attack = COEFF_BITS'($urandom_range(0, 32767));
                default: attack = COEFF_BITS'($urandom_range(60000, COEFF_MAX));
            endcase
            case ($urandom_range(0, 2))
                0:       release_pole_val = COEFF_BITS'($urandom);
                1:       release_pole_val = COEFF_BITS'($urandom_range(0, 32767));
                default: release_pole_val = COEFF_BITS'($urandom_range(60000, COEFF_MAX));
            endcase
            case ($urandom_range(0, 3))
                0:       cooldown = COOLDOWN_BITS'($urandom);
                3:       cooldown = '0;
                default: cooldown = COOLDOWN_BITS'($urandom_range(0, 40));
            endcase
        end
        s.attack_coeff  = {8'($urandom), attack};
        s.release_coeff = {8'($urandom), release_pole_val};
        s.cooldown_length = {8'($urandom), cooldown};
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    function automatic frame_t frame_of(logic [SAMPLE_BITS-1:0] ml, logic [SAMPLE_BITS-1:0] mr,
                                        logic [SAMPLE_BITS-1:0] sl, logic [SAMPLE_BITS-1:0] sr,
                                        logic mm, logic sm, logic sp, logic be);
        frame_t f;
        f.main_left    = ml;
        f.main_right   = mr;
        f.side_left    = sl;
        f.side_right   = sr;
        f.main_mono    = mm;
        f.side_mono    = sm;
        f.side_present = sp;
        f.block_end    = be;
        return f;
    endfunction

    // Sends one frame word. The sender works in bursts; between bursts it may drop
    // tvalid for a random number of cycles. The prediction is made at acceptance.
    task automatic send_frame(input frame_t f);
        report_t     r;
        int unsigned pause;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            pause      = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (pause != 0) begin
                s_tvalid <= 1'b0;
                repeat (pause) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {f.side_right, f.side_left, f.main_right, f.main_left};
        s_tuser  <= {f.side_present, f.side_mono, f.main_mono};
        s_tlast  <= f.block_end;
        do
            @(posedge clk);
        while (!s_tready);
        track_frame(f, r);
        reports_due.push_back(r);
        frames_sent++;
        main_trig_seen += r.main_trigger;
        side_trig_seen += r.side_trigger;
        blocks_closed  += f.block_end;
    endtask

    // Stops sending and waits until the block has drained, so that registers may
    // be written again. The settle cycles cover the input and result registers.
    task automatic wait_for_reports();
        s_tvalid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] draw_sample(level_kind_t k);
        logic [SAMPLE_BITS-1:0] m;
        case (k)
            LVL_SILENT: m = SAMPLE_BITS'($urandom_range(0, 15));
            LVL_QUIET:  m = SAMPLE_BITS'($urandom_range(0, 4095));
            LVL_MID:    m = SAMPLE_BITS'($urandom_range(0, 2097151));
            LVL_LOUD:   m = SAMPLE_BITS'($urandom_range(4194304, POS_FULL_SCALE));
            LVL_EXTREME:
            begin
                case ($urandom_range(0, 3))
                    0:       return NEG_FULL_SCALE;
                    1:       return POS_FULL_SCALE;
                    2:       return MINUS_ONE;
                    default: return '0;
                endcase
            end
            default:    return SAMPLE_BITS'($urandom);
        endcase
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    // Frames come from segments of random loudness and length, so envelopes rise
    // past the threshold, decay below it and rise again; noise segments mix in.
    task automatic random_frame(output frame_t f);
        if (main_seg_left == 0) begin
            main_kind     = level_kind_t'($urandom_range(LVL_SILENT, LVL_NOISE));
            main_seg_left = $urandom_range(1, 40);
        end
        if (side_seg_left == 0) begin
            side_kind     = level_kind_t'($urandom_range(LVL_SILENT, LVL_NOISE));
            side_seg_left = $urandom_range(1, 40);
        end
        main_seg_left--;
        side_seg_left--;
        f = frame_of(draw_sample(main_kind), draw_sample(main_kind),
                     draw_sample(side_kind), draw_sample(side_kind),
                     $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                     $urandom_range(0, 7) != 0, $urandom_range(0, 9) == 0);
    endtask

    // ------------------------------------------------------------------
    // Output side: stall pattern, result checking and watchdog
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input bit has_want,
                                   input report_t want, input report_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t ns: %s", $time, what);
            if (has_want)
                $display("  expected mt=%b st=%b bt=%b main=%0d side=%0d last=%b",
                         want.main_trigger, want.side_trigger, want.block_trigger,
                         want.main_level, want.side_level, want.last_of_block);
            $display("  actual   mt=%b st=%b bt=%b main=%0d side=%0d last=%b",
                     got.main_trigger, got.side_trigger, got.block_trigger,
                     got.main_level, got.side_level, got.last_of_block);
        end
    endtask

    always @(posedge clk)
    begin
        report_t got;
        report_t want;

        // Values read here are the ones the block saw at this edge.
        if (rst_n && m_tvalid && m_tready) begin
            got.main_trigger  = m_tdata[0];
            got.side_trigger  = m_tdata[1];
            got.block_trigger = m_tdata[2];
            got.main_level    = m_tdata[3 +: LEVEL_BITS];
            got.side_level    = m_tdata[3 + LEVEL_BITS +: LEVEL_BITS];
            got.last_of_block = m_tlast;
            if (reports_due.size() == 0) begin
                report_mismatch("result word with no frame outstanding", 1'b0, '0, got);
            end else begin
                want = reports_due.pop_front();
                words_checked++;
                if (got !== want)
                    report_mismatch("result word differs from prediction", 1'b1, want, got);
            end
        end

        // The receiver alternates runs of ready and stall of random lengths.
        if (rx_stall_max == 0) begin
            m_tready <= 1'b1;
        end else begin
            if (ready_hold == 0) begin
                ready_phase = !ready_phase;
                ready_hold  = ready_phase ? $urandom_range(1, 16)
                                          : $urandom_range(1, rx_stall_max);
            end
            ready_hold--;
            m_tready <= ready_phase;
        end

        // Any word moving on either side shows that the block is alive.
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("No word moved for %0d cycles; %0d results outstanding.",
                     idle_cycles, reports_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values of the registers: main path on with a slow attack, sidechain
    // off, so a run of full-scale frames has to build up before it triggers.
    task automatic test_reset_defaults();
        gap_max      = 3;
        rx_stall_max = 4;
        send_frame(frame_of('0, '0, '0, '0, 1'b0, 1'b0, 1'b1, 1'b0));
        repeat (6)
            send_frame(frame_of(NEG_FULL_SCALE, POS_FULL_SCALE, POS_FULL_SCALE, NEG_FULL_SCALE,
                                1'b0, 1'b0, 1'b1, 1'b0));
        send_frame(frame_of(POS_FULL_SCALE, '0, '0, '0, 1'b1, 1'b1, 1'b1, 1'b1));
        wait_for_reports();
    endtask

    // Instant attack and release make the envelope equal the magnitude, which
    // shows the mono copy, the absent sidechain and the full-scale negative sample
    // directly. Then the slowest poles move the envelope by the difference divided by
    // 2^COEFF_BITS, rounded up, per frame, and a full-scale threshold can never be exceeded.
    task automatic test_fast_envelopes();
        apply_settings(plain_settings(1'b1, 1'b1, '0, '0, '0, '0), 1'b0);
        send_frame(frame_of(24'd100, NEG_FULL_SCALE, NEG_FULL_SCALE, 24'd5,
                            1'b1, 1'b0, 1'b1, 1'b0));
        send_frame(frame_of(24'd100, 24'd100, POS_FULL_SCALE, POS_FULL_SCALE,
                            1'b0, 1'b1, 1'b0, 1'b0));
        send_frame(frame_of('0, '0, '0, '0, 1'b0, 1'b0, 1'b1, 1'b0));
        send_frame(frame_of(MINUS_ONE, '0, '0, 24'd1, 1'b0, 1'b0, 1'b1, 1'b1));
        wait_for_reports();

        apply_settings(plain_settings(1'b1, 1'b1, LEVEL_FULL_SCALE, COEFF_MAX, COEFF_MAX, '0),
                       1'b0);
        send_frame(frame_of(POS_FULL_SCALE, POS_FULL_SCALE, POS_FULL_SCALE, POS_FULL_SCALE,
                            1'b0, 1'b0, 1'b1, 1'b0));
        send_frame(frame_of('0, '0, '0, '0, 1'b0, 1'b0, 1'b1, 1'b0));
        send_frame(frame_of(NEG_FULL_SCALE, NEG_FULL_SCALE, NEG_FULL_SCALE, NEG_FULL_SCALE,
                            1'b0, 1'b0, 1'b1, 1'b0));
        wait_for_reports();

        apply_settings(plain_settings(1'b1, 1'b1, LEVEL_FULL_SCALE, '0, '0, '0), 1'b0);
        send_frame(frame_of(NEG_FULL_SCALE, NEG_FULL_SCALE, NEG_FULL_SCALE, NEG_FULL_SCALE,
                            1'b0, 1'b0, 1'b1, 1'b1));
        wait_for_reports();
    endtask

    // Alternating loud and quiet frames with a three-sample cooldown: the second
    // rising edge falls inside the cooldown and must be suppressed, the third not.
    task automatic test_cooldown();
        frame_t loud;
        frame_t quiet;
        loud  = frame_of(24'd500000, 24'd20, '0, '0, 1'b0, 1'b0, 1'b1, 1'b0);
        quiet = frame_of(24'd3, 24'd3, '0, '0, 1'b0, 1'b0, 1'b1, 1'b0);
        gap_max      = 0;
        rx_stall_max = 0;
        apply_settings(plain_settings(1'b1, 1'b0, 24'd1000, '0, '0, 16'd3), 1'b0);
        for (int i = 0; i < 3; i++) begin
            send_frame(loud);
            send_frame(quiet);
        end
        loud.block_end = 1'b1;
        send_frame(loud);
        wait_for_reports();
    endtask

    // Both paths frozen: the levels stay where they were and nothing triggers.
    task automatic test_frozen_paths();
        gap_max      = 6;
        rx_stall_max = 10;
        apply_settings(plain_settings(1'b0, 1'b1, '0, '0, '0, 16'd5), 1'b0);
        send_frame(frame_of('0, '0, POS_FULL_SCALE, '0, 1'b0, 1'b0, 1'b0, 1'b0));
        wait_for_reports();
        apply_settings(plain_settings(1'b0, 1'b0, '0, '0, '0, 16'd5), 1'b0);
        send_frame(frame_of('0, '0, POS_FULL_SCALE, '0, 1'b0, 1'b0, 1'b1, 1'b0));
        send_frame(frame_of(NEG_FULL_SCALE, '0, '0, '0, 1'b1, 1'b0, 1'b1, 1'b1));
        wait_for_reports();
    endtask

    // Several phases of segment-shaped random frames, each under its own register
    // settings and idling pattern; the first phases use only extreme settings.
    task automatic test_random_traffic();
        frame_t f;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            apply_settings(random_settings(p < 2), p % 2 == 1);
            case (p % 3)
                0:
                begin
                    gap_max      = 0;
                    rx_stall_max = 0;
                end
                1:
                begin
                    gap_max      = 4;
                    rx_stall_max = 6;
                end
                default:
                begin
                    gap_max      = 20;
                    rx_stall_max = 30;
                end
            endcase
            main_seg_left = 0;
            side_seg_left = 0;
            repeat (FRAMES_PER_PHASE) begin
                random_frame(f);
                send_frame(f);
            end
            wait_for_reports();
        end
    endtask

    initial
    begin
        reset_tracker();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_fast_envelopes();
        test_cooldown();
        test_frozen_paths();
        test_random_traffic();
        wait_for_reports();

        $display("Sent %0d frames under %0d register settings, closing %0d blocks.",
                 frames_sent, settings_used, blocks_closed);
        $display("Checked %0d result words holding %0d main and %0d side triggers.",
                 words_checked, main_trig_seen, side_trig_seen);
        if (mismatches == 0 && reports_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
